@@ sv/fspa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package fspa_pkg;
    // built pool size and address width
    localparam int POOL_SLOTS   = 64;
    localparam int ADDRESS_BITS = 32;

    typedef enum logic [2:0] {
        K_INIT  = 3'd0,
        K_ALLOC = 3'd1,
        K_FREE  = 3'd2,
        K_OWNS  = 3'd3,
        K_SCAN  = 3'd4
    } t_kind;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NONE     = 3'd1;
    localparam logic [2:0] ST_RANGE    = 3'd2;
    localparam logic [2:0] ST_MISALIGN = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    localparam logic [1:0] REG_BASE = 2'd0;
    localparam logic [1:0] REG_SIZE = 2'd1;
    localparam logic [1:0] REG_CAP  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_DWAIT,
        S_LOC,
        S_MUL,
        S_EMIT,
        S_CLR,
        S_MARK,
        S_WALK,
        S_WEND
    } t_state;

    // divider control
    typedef struct packed {
        logic start;
    } t_div_ctl;
endpackage
`default_nettype wire

@@ sv/fspa_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module fspa_div #(
    parameter int ADDRESS_BITS = 32
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  fspa_pkg::t_div_ctl       i_ctl,
    input  wire [ADDRESS_BITS-1:0]   i_num,
    input  wire [15:0]               i_den,
    output logic                     o_done,
    output logic [ADDRESS_BITS-1:0]  o_quo,
    output logic [15:0]              o_rem
);
    import fspa_pkg::*;
    localparam int CW = $clog2(ADDRESS_BITS + 1);

    logic [ADDRESS_BITS-1:0] r_quo;
    logic [16:0]             r_rem;
    logic [CW-1:0]           r_cnt;
    logic                    r_busy;
    logic [16:0]             w_trial;

    assign w_trial = {r_rem[15:0], r_quo[ADDRESS_BITS-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(ADDRESS_BITS);
                r_quo  <= i_num;
                r_rem  <= '0;
            end else if (r_busy) begin
                if (w_trial >= {1'b0, i_den}) begin
                    r_rem <= w_trial - {1'b0, i_den};
                    r_quo <= {r_quo[ADDRESS_BITS-2:0], 1'b1};
                end else begin
                    r_rem <= w_trial;
                    r_quo <= {r_quo[ADDRESS_BITS-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_quo = r_quo;
    assign o_rem = r_rem[15:0];
endmodule
`default_nettype wire

@@ sv/fixed_slot_pool_allocator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Fixed-size slot pool allocator.
// Command channel: pulse i_start with i_kind / i_address while o_busy is low.
// Config: i_cfg_we/i_cfg_idx/i_cfg_data; user writes only while idle, unchecked.
// Results: o_valid strobes one cycle per result; o_last marks the final one.
// o_busy drops with the last strobe, except after init (see the init note).
// Init: a single result from the emit state, then the stack refill keeps o_busy
// high until the refill has written capacity stack entries.
// Allocate: a registered stack read, a multiply state, then the emit state.
// Release, ownership: the offset passes the bit-serial divider (S_DIV, S_DWAIT),
// then S_LOC and S_EMIT; an out-of-range address skips the divider.
// Scan: clear all POOL_SLOTS map entries, mark every stacked index, walk the
// capacity slots (one slot per cycle), then one closing state. Slot results trail
// the walk through the registered map read and a hold register.
// Reset refills the free stack; o_busy stays high during the refill.
// The receiver cannot stall: each result is shown for exactly one cycle.
module fixed_slot_pool_allocator (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_start,
    output logic                    o_busy,
    input  wire [2:0]               i_kind,
    input  wire [31:0]              i_address,
    input  wire                     i_cfg_we,
    input  wire [1:0]               i_cfg_idx,
    input  wire [31:0]              i_cfg_data,
    output logic                    o_valid,
    output logic [2:0]              o_status,
    output logic [31:0]             o_object_address,
    output logic [5:0]              o_slot_index,
    output logic [6:0]              o_free_slots,
    output logic [6:0]              o_used_slots,
    output logic                    o_last
);
    import fspa_pkg::*;
    localparam int IW = $clog2(POOL_SLOTS);
    localparam int DW = $clog2(POOL_SLOTS + 1);

    // configuration
    logic [31:0] r_base;
    logic [15:0] r_size;
    logic [6:0]  r_cap_reg;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base    <= '0;
            r_size    <= 16'd64;
            r_cap_reg <= 7'd64;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_BASE: r_base    <= i_cfg_data;
                REG_SIZE: r_size    <= i_cfg_data[15:0];
                REG_CAP:  r_cap_reg <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    logic [15:0]   w_size;
    logic [DW-1:0] w_cap;
    assign w_size = (r_size == '0) ? 16'd1 : r_size;
    always_comb begin
        if (r_cap_reg == '0) w_cap = DW'(1);
        else if (32'(r_cap_reg) > POOL_SLOTS) w_cap = DW'(POOL_SLOTS);
        else w_cap = DW'(r_cap_reg);
    end

    // state
    t_state r_state, n_state;
    logic [DW-1:0]           r_depth;
    logic [31:0]             r_allocs;
    logic [IW-1:0]           r_stack [POOL_SLOTS];
    logic                    r_map   [POOL_SLOTS];
    logic [DW-1:0]           r_i;
    logic [2:0]              r_kind;
    logic [ADDRESS_BITS-1:0] r_off;
    logic [IW-1:0]           r_idx;
    logic [2:0]              r_st;
    logic                    r_fill;
    logic [31:0]             r_prod;
    // registered memory read data
    logic [IW-1:0]           r_stk_rd;
    logic                    r_map_rd;
    // scan pipeline
    logic                    r_mark_ok;
    logic                    r_chk_ok;
    logic [IW-1:0]           r_chk_idx;
    logic [31:0]             r_chk_addr;
    logic [31:0]             r_waddr;
    logic                    r_hold_valid;
    logic [IW-1:0]           r_hold_idx;
    logic [31:0]             r_hold_addr;

    // divider
    t_div_ctl                w_div_ctl;
    logic                    w_div_done;
    logic [ADDRESS_BITS-1:0] w_quo;
    logic [15:0]             w_rem;
    fspa_div #(.ADDRESS_BITS(ADDRESS_BITS)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (w_div_ctl),
        .i_num  (r_off),
        .i_den  (w_size),
        .o_done (w_div_done),
        .o_quo  (w_quo),
        .o_rem  (w_rem)
    );

    logic [22:0] w_limit;
    assign w_limit = 23'(w_size) * 23'(w_cap);
    logic w_range_bad;
    assign w_range_bad = r_off >= ADDRESS_BITS'(w_limit);

    logic w_accept;
    assign w_accept = i_start && !o_busy;
    assign o_busy   = (r_state != S_IDLE) || r_fill;
    assign w_div_ctl.start = (r_state == S_DIV) && !w_range_bad;

    // memory ports
    logic [IW-1:0] w_stk_raddr;
    logic          w_stk_we;
    logic [IW-1:0] w_stk_waddr;
    logic [IW-1:0] w_stk_wdata;
    logic          w_map_we;
    logic [IW-1:0] w_map_waddr;
    logic          w_map_wdata;
    logic          w_mark_in;
    logic          w_found;

    // stack top while idle, stack entry r_i while marking
    assign w_stk_raddr = (r_state == S_MARK) ? IW'(r_i) : IW'(r_depth - 1'b1);
    assign w_mark_in   = r_mark_ok && (DW'(r_stk_rd) < w_cap);
    assign w_found     = r_chk_ok && !r_map_rd;

    // stack write: refill sweep or release push
    always_comb begin
        w_stk_we    = 1'b0;
        w_stk_waddr = IW'(r_i);
        w_stk_wdata = IW'(w_cap - 1'b1 - r_i);
        if (r_fill) begin
            w_stk_we = 1'b1;
        end else if (r_state == S_LOC && r_kind == K_FREE && r_st == ST_OK
                     && w_rem == '0 && r_depth < w_cap) begin
            w_stk_we    = 1'b1;
            w_stk_waddr = IW'(r_depth);
            w_stk_wdata = IW'(w_quo);
        end
    end

    // map write: clear pass, then mark stacked indices
    always_comb begin
        w_map_we    = 1'b0;
        w_map_waddr = IW'(r_i);
        w_map_wdata = 1'b0;
        if (r_state == S_CLR) begin
            w_map_we = 1'b1;
        end else if (w_mark_in) begin
            w_map_we    = 1'b1;
            w_map_waddr = r_stk_rd;
            w_map_wdata = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_stk_we) r_stack[w_stk_waddr] <= w_stk_wdata;
        r_stk_rd <= r_stack[w_stk_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_map_we) r_map[w_map_waddr] <= w_map_wdata;
        r_map_rd <= r_map[IW'(r_i)];
    end

    logic          w_emit;
    logic [2:0]    w_est;
    logic [31:0]   w_eaddr;
    logic [5:0]    w_eidx;
    logic          w_elast;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_accept) begin
                unique case (i_kind)
                    K_INIT:  n_state = S_EMIT;
                    K_ALLOC: n_state = S_MUL;
                    K_FREE:  n_state = S_DIV;
                    K_OWNS:  n_state = S_DIV;
                    K_SCAN:  n_state = S_CLR;
                    default: n_state = S_IDLE;
                endcase
            end
            S_DIV:   n_state = w_range_bad ? S_LOC : S_DWAIT;
            S_DWAIT: if (w_div_done) n_state = S_LOC;
            S_LOC:   n_state = S_EMIT;
            S_MUL:   n_state = S_EMIT;
            S_EMIT:  n_state = S_IDLE;
            S_CLR:   if (r_i == DW'(POOL_SLOTS - 1)) n_state = S_MARK;
            S_MARK:  if (r_i >= r_depth) n_state = S_WALK;
            S_WALK:  if (r_i >= w_cap) n_state = S_WEND;
            S_WEND:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // result mux; a found slot is held until the next one shows whether it is last
    always_comb begin
        w_emit  = 1'b0;
        w_est   = r_st;
        w_eaddr = '0;
        w_eidx  = '0;
        w_elast = 1'b1;
        unique case (r_state)
            S_EMIT: begin
                w_emit = 1'b1;
                if (r_kind == K_ALLOC && r_st == ST_OK) begin
                    w_eaddr = r_prod;
                    w_eidx  = 6'(r_idx);
                end else if ((r_kind == K_FREE || r_kind == K_OWNS) && r_st == ST_OK) begin
                    w_eidx = 6'(r_idx);
                end
            end
            S_WALK: begin
                if (w_found && r_hold_valid) begin
                    w_emit  = 1'b1;
                    w_est   = ST_OK;
                    w_eaddr = r_hold_addr;
                    w_eidx  = 6'(r_hold_idx);
                    w_elast = 1'b0;
                end
            end
            S_WEND: begin
                w_emit = 1'b1;
                if (r_hold_valid) begin
                    w_est   = ST_OK;
                    w_eaddr = r_hold_addr;
                    w_eidx  = 6'(r_hold_idx);
                end else begin
                    w_est = ST_NONE;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth      <= '0;
            r_allocs     <= '0;
            r_fill       <= 1'b1;
            r_i          <= '0;
            o_valid      <= 1'b0;
            r_mark_ok    <= 1'b0;
            r_chk_ok     <= 1'b0;
            r_hold_valid <= 1'b0;
        end else begin
            o_valid <= w_emit;
            if (w_emit) begin
                o_status         <= w_est;
                o_object_address <= w_eaddr;
                o_slot_index     <= w_eidx;
                o_free_slots     <= 7'(r_depth);
                o_used_slots     <= (w_cap > r_depth) ? 7'(w_cap - r_depth) : 7'd0;
                o_last           <= w_elast;
            end
            // read-valid flags of the scan pipeline
            r_mark_ok <= (r_state == S_MARK) && (r_i < r_depth);
            r_chk_ok  <= (r_state == S_WALK) && (r_i < w_cap);
            // stack refill sweep
            if (r_fill) begin
                r_i <= r_i + 1'b1;
                if (r_i + 1'b1 >= w_cap) begin
                    r_fill  <= 1'b0;
                    r_depth <= w_cap;
                    r_i     <= '0;
                end
            end
            unique case (r_state)
                S_IDLE: if (w_accept) begin
                    r_kind       <= i_kind;
                    r_off        <= ADDRESS_BITS'(i_address) - ADDRESS_BITS'(r_base);
                    r_st         <= ST_OK;
                    r_i          <= '0;
                    r_waddr      <= r_base;
                    r_hold_valid <= 1'b0;
                    if (i_kind == K_INIT) begin
                        r_depth  <= w_cap;
                        r_allocs <= '0;
                    end
                    if (i_kind == K_ALLOC) begin
                        if (r_depth == '0) r_st <= ST_NONE;
                        else begin
                            r_depth  <= r_depth - 1'b1;
                            r_allocs <= r_allocs + 1'b1;
                        end
                    end
                end
                S_DIV: if (w_range_bad) r_st <= ST_RANGE;
                S_LOC: begin
                    if (r_st == ST_OK) begin
                        if (w_rem != '0) r_st <= ST_MISALIGN;
                        else begin
                            r_idx <= IW'(w_quo);
                            if (r_kind == K_FREE) begin
                                if (r_depth >= w_cap) r_st <= ST_FULL;
                                else r_depth <= r_depth + 1'b1;
                            end
                        end
                    end
                end
                S_MUL: begin
                    r_idx  <= r_stk_rd;
                    r_prod <= r_base + 32'(r_stk_rd) * 32'(w_size);
                end
                S_EMIT: if (r_kind == K_INIT) r_fill <= 1'b1;
                S_CLR: r_i <= (r_i == DW'(POOL_SLOTS - 1)) ? '0 : r_i + 1'b1;
                S_MARK: r_i <= (r_i < r_depth) ? r_i + 1'b1 : '0;
                S_WALK: begin
                    if (r_i < w_cap) begin
                        r_chk_idx  <= IW'(r_i);
                        r_chk_addr <= r_waddr;
                        r_waddr    <= r_waddr + 32'(w_size);
                        r_i        <= r_i + 1'b1;
                    end
                    if (w_found) begin
                        r_hold_valid <= 1'b1;
                        r_hold_idx   <= r_chk_idx;
                        r_hold_addr  <= r_chk_addr;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire
